FILE: rtl/tkf_pkg.sv
package tkf_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_BUBBLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic lookup;
    logic update;
    logic bubble;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_zero;
    logic bubble_stop;
    logic emit_done;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/tkf_ctrl.sv
module tkf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  tkf_pkg::sts_t sts,
  output tkf_pkg::cmd_t cmd,
  output logic          in_tready
);

  tkf_pkg::state_t state_r;
  tkf_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tkf_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      tkf_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = tkf_pkg::ST_IDLE;
        end
      end
      tkf_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.in_zero ? tkf_pkg::ST_EMIT : tkf_pkg::ST_LOOKUP;
        end
      end
      tkf_pkg::ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = tkf_pkg::ST_UPDATE;
      end
      tkf_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = tkf_pkg::ST_BUBBLE;
      end
      tkf_pkg::ST_BUBBLE: begin
        cmd.bubble = 1'b1;
        if (sts.bubble_stop) begin
          state_nxt = tkf_pkg::ST_EMIT;
        end
      end
      tkf_pkg::ST_EMIT: begin
        if (sts.emit_done) begin
          state_nxt = tkf_pkg::ST_IDLE;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      default: begin
        state_nxt = tkf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/tkf_datapath.sv
module tkf_datapath #(
  parameter int MAX_K      = 8,
  parameter int VALUE_BITS = 8,
  parameter int COUNT_BITS = 16,
  parameter int DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tkf_pkg::cmd_t        cmd,
  input  logic [DATA_BITS-1:0] in_tdata,
  input  logic                 cfg_valid,
  input  logic [3:0]           cfg_data,
  input  logic                 out_tready,
  output tkf_pkg::sts_t        sts,
  output logic                 out_tvalid,
  output logic [DATA_BITS-1:0] out_tdata,
  output logic                 out_tlast
);

  localparam int KW    = $clog2(MAX_K + 1);
  localparam int DEPTH = 1 << VALUE_BITS;

  logic [COUNT_BITS-1:0] cnt_mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic [VALUE_BITS-1:0] clr_addr_r;

  logic [VALUE_BITS-1:0] slot_val_r [MAX_K+1];
  logic [COUNT_BITS-1:0] slot_cnt_r [MAX_K+1];
  logic [MAX_K:0]        slot_nz;

  logic [VALUE_BITS-1:0] val_r;
  logic [COUNT_BITS-1:0] cur_cnt_r;
  logic [KW-1:0]         pos_r;
  logic [KW-1:0]         found_pos;
  logic [KW-1:0]         pos_m1;
  logic [VALUE_BITS-1:0] up_val;
  logic [COUNT_BITS-1:0] up_cnt;
  logic                  moves_up;

  logic [3:0]            k_r;
  logic [KW-1:0]         k_eff;
  logic [KW-1:0]         idx_r;
  logic [KW-1:0]         idx_p1;

  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_val_r;
  logic                  out_last_r;

  // count table: clearing pass, then read-modify-write of one entry per item
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      cnt_mem[clr_addr_r] <= '0;
    end else if (cmd.update) begin
      cnt_mem[val_r] <= (&rd_data_r) ? rd_data_r : rd_data_r + 1'b1;
    end
    rd_data_r <= cnt_mem[val_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 4'd4;
    end else if (cfg_valid) begin
      k_r <= cfg_data;
    end
  end

  // search of the ranked slots, first match wins
  always_comb begin
    found_pos = KW'(MAX_K);
    for (int j = MAX_K - 1; j >= 0; j--) begin
      if (slot_val_r[j] == val_r) begin
        found_pos = KW'(j);
      end
    end
  end

  always_comb begin
    for (int i = 0; i <= MAX_K; i++) begin
      slot_nz[i] = (slot_val_r[i] != '0);
    end
  end

  assign pos_m1   = (pos_r == '0) ? '0 : pos_r - 1'b1;
  assign up_val   = slot_val_r[pos_m1];
  assign up_cnt   = slot_cnt_r[pos_m1];
  assign moves_up = (pos_r != '0) &&
                    ((cur_cnt_r > up_cnt) || ((cur_cnt_r == up_cnt) && (val_r < up_val)));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_r <= in_tdata[VALUE_BITS-1:0];
    end
    if (cmd.lookup) begin
      pos_r <= found_pos;
    end else if (cmd.bubble && moves_up) begin
      pos_r <= pos_m1;
    end
    if (cmd.update) begin
      cur_cnt_r <= (&rd_data_r) ? rd_data_r : rd_data_r + 1'b1;
    end
  end

  // moving item shifts the slot above down one place per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAX_K; i++) begin
        slot_val_r[i] <= '0;
        slot_cnt_r[i] <= '0;
      end
    end else if (cmd.bubble) begin
      if (moves_up) begin
        slot_val_r[pos_r] <= up_val;
        slot_cnt_r[pos_r] <= up_cnt;
      end else begin
        slot_val_r[pos_r] <= val_r;
        slot_cnt_r[pos_r] <= cur_cnt_r;
      end
    end
  end

  assign k_eff  = (32'(k_r) > 32'(MAX_K)) ? KW'(MAX_K) : KW'(k_r);
  assign idx_p1 = idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= '0;
    end else if (cmd.emit) begin
      idx_r <= idx_p1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_val_r  <= slot_val_r[idx_r];
      out_last_r <= (idx_p1 == k_eff) || !slot_nz[idx_p1];
    end
  end

  assign sts.clr_last    = &clr_addr_r;
  assign sts.in_zero     = (in_tdata[VALUE_BITS-1:0] == '0);
  assign sts.bubble_stop = !moves_up;
  assign sts.emit_done   = (idx_r >= k_eff) || !slot_nz[idx_r];
  assign sts.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_BITS'(out_val_r);
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/top_k_frequent_stream.sv
// running top-k of the most frequent values in a stream
// in channel: in_tdata carries one value, zero is not counted
// cfg channel: cfg_data sets how many ranks are reported, always ready
// out channel: one item per reported rank, best first, out_tlast on the final one
// after reset a clearing pass over all 2^VALUE_BITS entries zeroes the count table,
// in_tready stays low during it; cfg writes are taken at all times
// per item: an accept, a table read, a count update, 1 to MAX_K+1 bubble
// steps over the ranked slots, then one emit per reported rank and a final check
// the bubble steps are done by the single compare unit that walks the ranked slots
// a zero value skips the read, update and bubble steps and only reports
// the next item can be accepted once the report loop has returned to idle after
// the last rank is loaded into the output register, even if it still waits;
// a stalled receiver holds the report loop until the output register is free
module top_k_frequent_stream #(
  parameter int MAX_K      = 8,
  parameter int VALUE_BITS = 8,
  parameter int COUNT_BITS = 16,
  parameter int DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DATA_BITS-1:0] in_tdata,   // value
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [3:0]           cfg_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_BITS-1:0] out_tdata,  // ranked_value
  output logic                 out_tlast
);

  tkf_pkg::cmd_t cmd;
  tkf_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  tkf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .sts       (sts),
    .cmd       (cmd),
    .in_tready (in_tready)
  );

  tkf_datapath #(
    .MAX_K      (MAX_K),
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS),
    .DATA_BITS  (DATA_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: test/tkf_rank_monitor.sv
`timescale 1ns / 100ps

module tkf_rank_monitor #(
  parameter int MAX_K      = 8,
  parameter int VALUE_BITS = 8,
  parameter int COUNT_BITS = 16,
  parameter int DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [DATA_BITS-1:0] in_tdata,   // value
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [3:0]           cfg_data,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [DATA_BITS-1:0] out_tdata,  // ranked_value
  input  logic                 out_tlast,
  output int                   mismatches,
  output int                   pending,
  output int                   items_seen,
  output int                   ranks_seen
);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } rank_t;

  rank_t                 expected_ranks[$];
  logic [COUNT_BITS-1:0] seen_count[2**VALUE_BITS];
  logic [VALUE_BITS-1:0] leaderboard[MAX_K+1];
  logic [3:0]            report_k;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t ns: %s, got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // true when value lo belongs above value hi
  function automatic bit outranks(input logic [VALUE_BITS-1:0] lo,
                                  input logic [VALUE_BITS-1:0] hi);
    if (seen_count[lo] > seen_count[hi]) return 1'b1;
    return (seen_count[lo] == seen_count[hi]) && (lo < hi);
  endfunction

  task automatic advance_ranking(input logic [VALUE_BITS-1:0] v);
    int                    pos;
    int                    j;
    int                    n;
    int                    shown;
    bit                    moving;
    logic [VALUE_BITS-1:0] above;
    rank_t                 entry;
    if (v != '0) begin
      if (seen_count[v] != '1) seen_count[v] = seen_count[v] + 1'b1;
      pos = MAX_K;
      for (j = 0; j < MAX_K; j++) begin
        if (pos == MAX_K && leaderboard[j] == v) pos = j;
      end
      if (pos == MAX_K) leaderboard[MAX_K] = v;
      moving = 1'b1;
      while (moving && pos > 0) begin
        if (outranks(leaderboard[pos], leaderboard[pos-1])) begin
          above              = leaderboard[pos-1];
          leaderboard[pos-1] = leaderboard[pos];
          leaderboard[pos]   = above;
          pos--;
        end else begin
          moving = 1'b0;
        end
      end
    end
    shown = (report_k > MAX_K) ? MAX_K : int'(report_k);
    n = 0;
    while (n < shown && leaderboard[n] != '0) begin
      entry.value = leaderboard[n];
      entry.last  = (n == shown - 1) || (leaderboard[n+1] == '0);
      expected_ranks.insert(expected_ranks.size(), entry);
      n++;
    end
  endtask

  always @(posedge clk) begin
    rank_t head;
    if (!rst_n) begin
      foreach (seen_count[i]) seen_count[i] = '0;
      foreach (leaderboard[i]) leaderboard[i] = '0;
      report_k = 4'd4;
      expected_ranks.delete();
      mismatches = 0;
      items_seen = 0;
      ranks_seen = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        ranks_seen++;
        if (expected_ranks.size() == 0) begin
          report_mismatch("ranked_value with no item pending", 32'(out_tdata), 32'd0);
        end else begin
          head = expected_ranks.pop_front();
          if (out_tdata !== DATA_BITS'(head.value))
            report_mismatch("ranked_value", 32'(out_tdata), 32'(head.value));
          if (out_tlast !== head.last)
            report_mismatch("is_last", 32'(out_tlast), 32'(head.last));
        end
      end
      if (cfg_valid && cfg_ready) report_k = cfg_data;
      if (in_tvalid && in_tready) begin
        items_seen++;
        advance_ranking(in_tdata[VALUE_BITS-1:0]);
      end
    end
    pending = expected_ranks.size();
  end

endmodule

FILE: test/tb_top_k_frequent_stream.sv
`timescale 1ns / 100ps

module tb_top_k_frequent_stream;

  localparam int MAX_K        = 8;
  localparam int VALUE_BITS   = 8;
  localparam int COUNT_BITS   = 16;
  localparam int DATA_BITS    = ((VALUE_BITS + 7) / 8) * 8;
  localparam int SETTLE_TICKS = 48;
  localparam int LEAD_ITEMS   = 6;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [DATA_BITS-1:0] in_tdata   = '0;   // value
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [3:0]           cfg_data   = 4'd0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DATA_BITS-1:0] out_tdata;         // ranked_value
  logic                 out_tlast;

  int mismatches;
  int pending;
  int items_seen;
  int ranks_seen;
  int settings_used = 0;
  int stall_left    = 0;
  bit ready_hold    = 1'b0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  top_k_frequent_stream #(
    .MAX_K(MAX_K), .VALUE_BITS(VALUE_BITS), .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  tkf_rank_monitor #(
    .MAX_K(MAX_K), .VALUE_BITS(VALUE_BITS), .COUNT_BITS(COUNT_BITS)
  ) monitor (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .mismatches(mismatches), .pending(pending),
    .items_seen(items_seen), .ranks_seen(ranks_seen)
  );

  // receiver back-pressure, mostly short stalls
  always @(negedge clk) begin
    if (ready_hold) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_value(input logic [VALUE_BITS-1:0] v, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_BITS'(v);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic set_k(input logic [3:0] k);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_list(input logic [VALUE_BITS-1:0] vals[$]);
    foreach (vals[i]) send_value(vals[i], pick_gap(1'b0));
  endtask

  initial begin : stimulus
    logic [VALUE_BITS-1:0] hot[12];
    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] lead_value;
    logic [3:0]            phase_k[8];
    int                    r;
    int                    w;
    bit                    calm;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset k: empty list, extremes, zero on a live list, tie, overflow past MAX_K
    send_list('{8'd0, 8'd255, 8'd1, 8'd255, 8'd0, 8'd5, 8'd3, 8'd10, 8'd11, 8'd12,
                8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'hAA, 8'h55});
    set_k(4'd0);
    send_list('{8'd1, 8'd0});
    set_k(4'd15);
    send_list('{8'h40, 8'd0});
    set_k(4'd8);
    send_list('{8'h80, 8'h7F});
    set_k(4'd1);
    send_list('{8'd3, 8'd255, 8'd0});

    phase_k = '{4'd2, 4'd8, 4'd0, 4'd15, 4'd1, 4'd9, 4'd3, 4'd7};
    phase_k[6] = 4'($urandom_range(3, 7));
    phase_k[7] = 4'($urandom_range(0, 15));
    for (int p = 0; p < 8; p++) begin
      set_k(phase_k[p]);
      calm = (p == 2) || (p == 5);
      ready_hold = calm;
      foreach (hot[i]) hot[i] = VALUE_BITS'($urandom_range(1, 255));
      for (int i = 0; i < 16; i++) begin
        r = $urandom_range(0, 99);
        if (r < 70) v = hot[$urandom_range(0, 11)];
        else if (r < 85) v = VALUE_BITS'($urandom_range(1, 255));
        else if (r < 92) v = '0;
        else if (r < 96) v = 8'd1;
        else v = 8'd255;
        send_value(v, pick_gap(calm));
      end
      ready_hold = 1'b0;
    end

    // build a clear leader, then let a newcomer challenge it
    set_k(4'd1);
    ready_hold = 1'b1;
    lead_value = VALUE_BITS'($urandom_range(1, 255));
    for (int i = 0; i < LEAD_ITEMS; i++) send_value(lead_value, 0);
    v = (lead_value == 8'd255) ? 8'd1 : lead_value + 8'd1;
    send_value(v, 0);
    send_value(v, 0);
    set_k(4'd8);
    ready_hold = 1'b0;
    send_list('{lead_value, v, 8'd0});

    in_tvalid <= 1'b0;
    for (w = 0; w < 20000 && pending != 0; w++) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);

    $display("%0d items, %0d ranked results, %0d k_in_use settings from 0 to 15",
             items_seen, ranks_seen, settings_used + 1);
    $display("leader %0d built up, then challenged by a neighbor value", lead_value);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

endmodule

FILE: top_k_frequent_stream.f
rtl/tkf_pkg.sv
rtl/tkf_ctrl.sv
rtl/tkf_datapath.sv
rtl/top_k_frequent_stream.sv
test/tkf_rank_monitor.sv
test/tb_top_k_frequent_stream.sv
